// ===== design/iralu_pkg.sv =====
// ----------------------------------------------------------------------------
// iralu_pkg: shared types and constants of the integer IR ALU
// Request/response structs, op codes, status codes, divider cell state.
// ----------------------------------------------------------------------------
`default_nettype none
package iralu_pkg;
   localparam int MAX_WIDTH = 64;
   localparam int ADDR_BITS = 16;
   localparam int WB        = 7;

   localparam logic [1:0] RT_BIN  = 2'd0;
   localparam logic [1:0] RT_CMP  = 2'd1;
   localparam logic [1:0] RT_CONV = 2'd2;

   localparam logic [3:0] OP_ADD  = 4'd0;
   localparam logic [3:0] OP_SUB  = 4'd1;
   localparam logic [3:0] OP_MUL  = 4'd2;
   localparam logic [3:0] OP_SDIV = 4'd3;
   localparam logic [3:0] OP_SREM = 4'd4;
   localparam logic [3:0] OP_UDIV = 4'd5;
   localparam logic [3:0] OP_UREM = 4'd6;
   localparam logic [3:0] OP_AND  = 4'd7;
   localparam logic [3:0] OP_OR   = 4'd8;
   localparam logic [3:0] OP_XOR  = 4'd9;
   localparam logic [3:0] OP_SHL  = 4'd10;
   localparam logic [3:0] OP_ASHR = 4'd11;
   localparam logic [3:0] OP_LSHR = 4'd12;

   localparam logic [3:0] CMP_EQ  = 4'd0;
   localparam logic [3:0] CMP_NE  = 4'd1;
   localparam logic [3:0] CMP_SGE = 4'd2;
   localparam logic [3:0] CMP_SGT = 4'd3;
   localparam logic [3:0] CMP_SLE = 4'd4;
   localparam logic [3:0] CMP_SLT = 4'd5;
   localparam logic [3:0] CMP_UGE = 4'd6;
   localparam logic [3:0] CMP_UGT = 4'd7;
   localparam logic [3:0] CMP_ULE = 4'd8;
   localparam logic [3:0] CMP_ULT = 4'd9;

   localparam logic [3:0] CV_ZEXT  = 4'd0;
   localparam logic [3:0] CV_SEXT  = 4'd1;
   localparam logic [3:0] CV_TRUNC = 4'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DIV0 = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;

   typedef struct packed {
      logic [1:0]           req_type;
      logic [3:0]           op;
      logic [WB-1:0]        operand_width;
      logic [63:0]          operand_a;
      logic [63:0]          operand_b;
      logic [WB-1:0]        target_width;
      logic [ADDR_BITS-1:0] dest_addr;
   } req_type_type;

   typedef struct packed {
      logic [63:0]          result_value;
      logic [WB-1:0]        result_width;
      logic [ADDR_BITS-1:0] store_addr;
      logic [1:0]           status;
   } rsp_type;

   // item travelling down the divider chain
   typedef struct packed {
      logic        vld;
      logic        is_div;    // take quotient
      logic        neg;       // negate final value
      logic [63:0] quo;       // dividend bits shifting out, quotient bits in
      logic [63:0] rem;
      logic [63:0] dsr;
      logic [63:0] mask;
      rsp_type     rsp;       // prepared response (div/rem value filled at end)
   } div_cell_type;

   function automatic logic [63:0] wmask(input logic [WB-1:0] w);
      logic [63:0] m;
      m = '1;
      if (w < WB'(64)) m = ~({64{1'b1}} << w);
      return m;
   endfunction

   function automatic logic [63:0] sext(input logic [63:0] v, input logic [WB-1:0] w);
      logic [63:0] m;
      logic [63:0] r;
      m = wmask(w);
      r = v & m;
      if (w != '0 && r[w[5:0] - 6'd1] && w < WB'(64)) r = r | ~m;
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== design/iralu_div_cell.sv =====
// ----------------------------------------------------------------------------
// iralu_div_cell: one restoring-division step
// Produces one quotient bit and hands the item to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none
module iralu_div_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire iralu_pkg::div_cell_type cell_in,
   output      iralu_pkg::div_cell_type cell_out
);
   import iralu_pkg::*;

   div_cell_type cell_ff, cell_in_c;
   logic [64:0]  trial;
   logic [64:0]  diff;

   always_comb begin
      cell_in_c = cell_in;
      trial     = {cell_in.rem, cell_in.quo[63]};
      diff      = trial - {1'b0, cell_in.dsr};
      if (!diff[64]) begin
         cell_in_c.rem = diff[63:0];
         cell_in_c.quo = {cell_in.quo[62:0], 1'b1};
      end else begin
         cell_in_c.rem = trial[63:0];
         cell_in_c.quo = {cell_in.quo[62:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cell_ff.vld <= 1'b0;
      else       cell_ff.vld <= cell_in_c.vld;
      cell_ff.is_div <= cell_in_c.is_div;
      cell_ff.neg    <= cell_in_c.neg;
      cell_ff.quo    <= cell_in_c.quo;
      cell_ff.rem    <= cell_in_c.rem;
      cell_ff.dsr    <= cell_in_c.dsr;
      cell_ff.mask   <= cell_in_c.mask;
      cell_ff.rsp    <= cell_in_c.rsp;
   end

   assign cell_out = cell_ff;
endmodule
`default_nettype wire

// ===== design/iralu_mul_stage.sv =====
// ----------------------------------------------------------------------------
// iralu_mul_stage: 64x64 low-half multiplier in registered partial products
// Three 32x32 products are registered, then summed combinationally in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module iralu_mul_stage (
   input  wire logic        clock,
   input  wire logic [63:0] a,
   input  wire logic [63:0] b,
   output      logic [63:0] p
);
   logic [63:0] ll_ff, lh_ff, hl_ff;

   always_ff @(posedge clock) begin
      ll_ff <= 64'(a[31:0]) * 64'(b[31:0]);
      lh_ff <= 64'(a[31:0]) * 64'(b[63:32]);
      hl_ff <= 64'(a[63:32]) * 64'(b[31:0]);
   end

   assign p = ll_ff + {lh_ff[31:0] + hl_ff[31:0], 32'd0};
endmodule
`default_nettype wire

// ===== design/ir_integer_alu.sv =====
// ----------------------------------------------------------------------------
// ir_integer_alu: integer IR operation unit
// One request per cycle, busy never asserted. Every request, whatever its op,
// runs down the 64-cell division chain: one head register, 64 cells and one
// output register, and rsp_valid comes from that output register. mul is
// computed beside the chain in one registered stage and merged in at the
// chain head. Responses leave in request order. The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none
module ir_integer_alu (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output      logic                    busy,
   input  wire iralu_pkg::req_type_type req_data,
   output      logic                    rsp_valid,
   output      iralu_pkg::rsp_type      rsp_data
);
   import iralu_pkg::*;

   localparam int NC = 64;

   div_cell_type chain [NC+1];
   div_cell_type head_ff, head_in;
   logic         mul_vld_ff;
   logic [63:0]  mul_p;
   logic [63:0]  mul_mask_ff;
   logic         out_vld_ff;
   rsp_type      out_ff, out_in;

   logic [63:0] a, b, sa, sb, m, r;
   logic [WB-1:0] w, tw;
   logic        w_ok, tw_ok, is_mul, is_dv, t;
   logic [1:0]  st;
   logic [WB-1:0] rw;

   assign busy = 1'b0;

   always_comb begin
      w     = req_data.operand_width;
      tw    = req_data.target_width;
      w_ok  = w >= WB'(1) && w <= WB'(MAX_WIDTH);
      tw_ok = tw >= WB'(1) && tw <= WB'(MAX_WIDTH);
      m     = wmask(w);
      a     = req_data.operand_a & m;
      b     = req_data.operand_b & m;
      sa    = sext(a, w);
      sb    = sext(b, w);
      r     = '0;
      st    = ST_BAD;
      rw    = WB'(1);
      t     = 1'b0;
      is_mul = 1'b0;
      is_dv  = 1'b0;
      head_in = '0;
      if (w_ok) begin
         unique case (req_data.req_type)
            RT_BIN: begin
               rw = w;
               st = ST_OK;
               case (req_data.op)
                  OP_ADD:  r = a + b;
                  OP_SUB:  r = a - b;
                  OP_MUL:  is_mul = 1'b1;
                  OP_SDIV, OP_SREM, OP_UDIV, OP_UREM: begin
                     if (b == '0) st = ST_DIV0;
                     else is_dv = 1'b1;
                  end
                  OP_AND:  r = a & b;
                  OP_OR:   r = a | b;
                  OP_XOR:  r = a ^ b;
                  OP_SHL:  r = (b >= 64'(w)) ? '0 : a << b[5:0];
                  OP_ASHR: r = (b >= 64'(w)) ? {64{sa[63]}} :
                                64'($signed(sa) >>> b[5:0]);
                  OP_LSHR: r = (b >= 64'(w)) ? '0 : a >> b[5:0];
                  default: begin
                     st = ST_BAD;
                     rw = WB'(1);
                  end
               endcase
            end
            RT_CMP: begin
               st = ST_OK;
               case (req_data.op)
                  CMP_EQ:  t = a == b;
                  CMP_NE:  t = a != b;
                  CMP_SGE: t = $signed(sa) >= $signed(sb);
                  CMP_SGT: t = $signed(sa) >  $signed(sb);
                  CMP_SLE: t = $signed(sa) <= $signed(sb);
                  CMP_SLT: t = $signed(sa) <  $signed(sb);
                  CMP_UGE: t = a >= b;
                  CMP_UGT: t = a >  b;
                  CMP_ULE: t = a <= b;
                  CMP_ULT: t = a <  b;
                  default: st = ST_BAD;
               endcase
               r = {63'd0, t};
            end
            RT_CONV: begin
               if (tw_ok) begin
                  if (req_data.op == CV_ZEXT && tw >= w) begin
                     r = a; st = ST_OK; rw = tw;
                  end else if (req_data.op == CV_SEXT && tw >= w) begin
                     r = sa & wmask(tw); st = ST_OK; rw = tw;
                  end else if (req_data.op == CV_TRUNC && tw <= w) begin
                     r = a & wmask(tw); st = ST_OK; rw = tw;
                  end
               end
            end
            default: st = ST_BAD;
         endcase
      end
      if (st != ST_OK) begin
         r = '0;
         if (st == ST_BAD) rw = WB'(1);
      end
      head_in.vld    = start;
      head_in.mask   = m;
      head_in.is_div = 1'b0;
      head_in.neg    = 1'b0;
      head_in.quo    = '0;
      head_in.dsr    = '0;
      head_in.rsp.result_value = r & wmask(rw);
      head_in.rsp.result_width = rw;
      head_in.rsp.store_addr   = req_data.dest_addr;
      head_in.rsp.status       = st;
      if (is_dv) begin
         head_in.is_div = req_data.op == OP_SDIV || req_data.op == OP_UDIV;
         if (req_data.op == OP_SDIV || req_data.op == OP_SREM) begin
            head_in.quo = sa[63] ? -sa : sa;
            head_in.dsr = sb[63] ? -sb : sb;
            head_in.neg = (req_data.op == OP_SDIV) ? (sa[63] ^ sb[63]) : sa[63];
         end else begin
            head_in.quo = a;
            head_in.dsr = b;
         end
      end
   end

   // mul runs beside the chain; its product is parked in the chain payload
   iralu_mul_stage u_mul (.clock(clock), .a(a), .b(b), .p(mul_p));

   always_ff @(posedge clock) begin
      head_ff     <= head_in;
      mul_vld_ff  <= reset ? 1'b0 : (start && is_mul);
      mul_mask_ff <= m;
   end

   always_comb begin
      chain[0] = head_ff;
      chain[0].vld = head_ff.vld & ~reset;
      if (mul_vld_ff) chain[0].rsp.result_value = mul_p & mul_mask_ff;
   end

   for (genvar i = 0; i < NC; i++) begin : g_cell
      iralu_div_cell u_cell (.clock(clock), .reset(reset),
                             .cell_in(chain[i]), .cell_out(chain[i+1]));
   end

   always_comb begin
      out_in = chain[NC].rsp;
      if (chain[NC].dsr != '0 || chain[NC].is_div || chain[NC].neg) begin
         if (chain[NC].is_div)
            out_in.result_value = (chain[NC].neg ? -chain[NC].quo : chain[NC].quo)
                                  & chain[NC].mask;
         else
            out_in.result_value = (chain[NC].neg ? -chain[NC].rem : chain[NC].rem)
                                  & chain[NC].mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else       out_vld_ff <= chain[NC].vld;
      out_ff <= out_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;
endmodule
`default_nettype wire
